// File: src/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and constants for the circular FIFO queue and its cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package cfq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic fill;   // accepted insert on a queue that is not full
    logic shift;  // accepted remove on a queue that is not empty
    logic clear;  // accepted clear
  } cell_ctrl_t;

endpackage : cfq_pkg

`default_nettype wire

// File: src/cfq_if.sv
// ----------------------------------------------------------------------------
// cfq_if
// Valid/ready channels for queue operations and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfq_in_if;
  import cfq_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink   (input valid, input operation, input data_in, output ready);
endinterface : cfq_in_if

interface cfq_out_if #(
  parameter int unsigned DEPTH = 8
);
  import cfq_pkg::*;

  // The occupancy field is wide enough to count a completely full queue.
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] removed_value;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] front_value;
  logic [DATA_W-1:0] rear_value;
  logic [CNT_W-1:0]  occupancy;
  logic              is_empty;
  logic              is_full;

  modport source (
    output valid, output removed_value, output status, output front_value,
    output rear_value, output occupancy, output is_empty, output is_full,
    input ready
  );
  modport sink (
    input valid, input removed_value, input status, input front_value,
    input rear_value, input occupancy, input is_empty, input is_full,
    output ready
  );
endinterface : cfq_out_if

`default_nettype wire

// File: src/cfq_cell.sv
// ----------------------------------------------------------------------------
// cfq_cell
// One slot of the queue chain: a data word and its occupied flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cfq_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic [cfq_pkg::DATA_W-1:0] data_i,
  input  wire logic                       prev_valid_i,
  input  wire logic                       next_valid_i,
  input  wire logic [cfq_pkg::DATA_W-1:0] next_data_i,
  output logic                            valid_o,
  output logic [cfq_pkg::DATA_W-1:0]      data_o
);
  import cfq_pkg::*;

  logic              valid_d, valid_q;
  logic [DATA_W-1:0] data_d, data_q;

  // The occupied flags form a thermometer code: the first empty cell
  // after an occupied one is where a new item lands.
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.fill) begin
      valid_d = valid_q | prev_valid_i;
      if (!valid_q && prev_valid_i) begin
        data_d = data_i;
      end
    end else if (ctrl_i.shift) begin
      valid_d = next_valid_i;
      data_d  = next_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule : cfq_cell

`default_nettype wire

// File: src/circular_fifo_queue.sv
// ----------------------------------------------------------------------------
// circular_fifo_queue
// Fixed-depth FIFO of data words with insert, remove and clear operations.
// ----------------------------------------------------------------------------
// The queue takes one operation per clock cycle while no result is held up
// at its output, and returns one result item for each, in the cycle after
// acceptance, from an output register; a new operation is taken while that
// result waits as long as the output side is ready. Words sit in a chain of
// DEPTH cells with the oldest in the first cell: a remove shifts the whole
// chain toward the front at once and an insert lands in the first free cell.
// Insert on a full queue and remove on an empty queue are refused with a
// status code; front, rear and removed value read 0 when there is nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_queue #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cfq_in_if.sink     in_i,
  cfq_out_if.source  out_o
);
  import cfq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0]  cell_valid;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  prev_valid;
  logic [DEPTH-1:0]  next_valid;
  logic [DATA_W-1:0] next_data [DEPTH];
  cell_ctrl_t        ctrl;

  logic [CNT_W-1:0]  count_d, count_q;
  logic [DATA_W-1:0] rear_d, rear_q;

  logic              out_valid_d, out_valid_q;
  logic [DATA_W-1:0] removed_d, removed_q;
  status_e           status_d, status_q;
  logic [DATA_W-1:0] front_d, front_q;
  logic [DATA_W-1:0] rear_out_d, rear_out_q;

  logic in_fire, out_fire, is_ins, is_rem, full, empty;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  assign full  = cell_valid[DEPTH-1];
  assign empty = !cell_valid[0];

  assign is_ins     = in_fire && (in_i.operation == OP_INSERT);
  assign is_rem     = in_fire && (in_i.operation == OP_REMOVE);
  assign ctrl.fill  = is_ins && !full;
  assign ctrl.shift = is_rem && !empty;
  assign ctrl.clear = in_fire && (in_i.operation == OP_CLEAR);

  // Chain wiring: the front cell always sees an occupied neighbor behind
  // it, and the last cell shifts in an empty slot.
  for (genvar i = 0; i < DEPTH; i++) begin : g_chain
    if (i == 0) begin : g_first
      assign prev_valid[i] = 1'b1;
    end else begin : g_mid
      assign prev_valid[i] = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_valid[i] = 1'b0;
      assign next_data[i]  = '0;
    end else begin : g_inner
      assign next_valid[i] = cell_valid[i+1];
      assign next_data[i]  = cell_data[i+1];
    end

    cfq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .data_i       (in_i.data_in),
      .prev_valid_i (prev_valid[i]),
      .next_valid_i (next_valid[i]),
      .next_data_i  (next_data[i]),
      .valid_o      (cell_valid[i]),
      .data_o       (cell_data[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.clear) begin
      count_d = '0;
    end else if (ctrl.fill) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl.shift) begin
      count_d = count_q - CNT_W'(1);
    end

    rear_d = ctrl.fill ? in_i.data_in : rear_q;

    status_d = ST_DONE;
    if (is_ins && full) begin
      status_d = ST_FULL;
    end else if (is_rem && empty) begin
      status_d = ST_EMPTY;
    end

    removed_d = ctrl.shift ? cell_data[0] : '0;

    if (count_d == '0) begin
      front_d    = '0;
      rear_out_d = '0;
    end else begin
      rear_out_d = rear_d;
      if (ctrl.shift) begin
        front_d = cell_data[1];
      end else if (ctrl.fill && empty) begin
        front_d = in_i.data_in;
      end else begin
        front_d = cell_data[0];
      end
    end

    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rear_q <= rear_d;
    if (in_fire) begin
      removed_q  <= removed_d;
      status_q   <= status_d;
      front_q    <= front_d;
      rear_out_q <= rear_out_d;
    end
  end

  // Occupancy and flags come straight from the count, which is updated
  // together with the result registers.
  assign out_o.valid         = out_valid_q;
  assign out_o.removed_value = removed_q;
  assign out_o.status        = status_q;
  assign out_o.front_value   = front_q;
  assign out_o.rear_value    = rear_out_q;
  assign out_o.occupancy     = count_q;
  assign out_o.is_empty      = (count_q == '0);
  assign out_o.is_full       = (count_q == CNT_W'(DEPTH));

endmodule : circular_fifo_queue

`default_nettype wire

// File: src/cfq_checker.sv
// ----------------------------------------------------------------------------
// cfq_checker
// Port-level checks on the queue's handshakes and result items.
// ----------------------------------------------------------------------------
`default_nettype none

module cfq_checker #(
  parameter int unsigned DEPTH = 8
) (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_ready_i,
  input wire logic                             out_valid_i,
  input wire logic                             out_ready_i,
  input wire logic [cfq_pkg::DATA_W-1:0]       removed_value_i,
  input wire logic [cfq_pkg::STAT_W-1:0]       status_i,
  input wire logic [cfq_pkg::DATA_W-1:0]       front_value_i,
  input wire logic [cfq_pkg::DATA_W-1:0]       rear_value_i,
  input wire logic [$clog2(DEPTH + 1)-1:0]     occupancy_i,
  input wire logic                             is_empty_i,
  input wire logic                             is_full_i
);
  import cfq_pkg::*;

  // A pending result that is not taken must stay offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // A stalled result blocks new operations, so none can overwrite it.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("operation accepted while result is stalled");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_FULL) |-> is_full_i && (removed_value_i == '0))
    else $error("full refusal on a queue that is not full");

  a_empty_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_EMPTY) |-> is_empty_i && (removed_value_i == '0))
    else $error("empty refusal on a queue that is not empty");

  a_empty_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_empty_i |->
      (front_value_i == '0) && (rear_value_i == '0) && (occupancy_i == '0))
    else $error("empty queue reports stored values");

endmodule : cfq_checker

bind circular_fifo_queue cfq_checker #(.DEPTH(DEPTH)) u_cfq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .removed_value_i (out_o.removed_value),
  .status_i        (out_o.status),
  .front_value_i   (out_o.front_value),
  .rear_value_i    (out_o.rear_value),
  .occupancy_i     (out_o.occupancy),
  .is_empty_i      (out_o.is_empty),
  .is_full_i       (out_o.is_full)
);

`default_nettype wire

// File: tb/sv/circular_fifo_queue_tb.sv
// ----------------------------------------------------------------------------
// circular_fifo_queue_tb
// Self-checking bench for the circular FIFO queue. A driver plays a backlog of
// insert, remove, clear and unused operations into the queue, a predictor
// tracks the stored words and computes the result item for each accepted
// operation, and a monitor compares every returned item field by field. Both
// handshake sides idle at random, the receiver once holds off long enough to
// back the queue up, and the sender once waits for all results to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fifo_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfq_pkg::*;

  localparam int unsigned QDEPTH      = 8;
  localparam int unsigned RAND_OPS    = 1800;
  localparam int unsigned PHASE1_AT   = 700;
  localparam int unsigned PHASE2_AT   = 1400;
  localparam int unsigned STALL_AT    = 300;
  localparam int unsigned STALL_LEN   = 200;
  localparam int unsigned DRAIN_AT    = 1000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data;
    bit                drain_first;
  } queue_op_t;

  typedef struct {
    logic [DATA_W-1:0] removed_value;
    status_e           status;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] rear_value;
    logic [3:0]        occupancy;
    logic              is_empty;
    logic              is_full;
  } outcome_t;

  logic clk;
  logic rst_n;

  cfq_in_if                    in_ch ();
  cfq_out_if #(.DEPTH(QDEPTH)) out_ch ();

  circular_fifo_queue #(.DEPTH(QDEPTH)) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  queue_op_t op_backlog[$];
  outcome_t  outcome_fifo[$];
  int        total_ops;
  int        accepted_ops;
  int        n_fail;
  int        stall_left;
  bit        stall_done;

  // Shadow copy of the queue contents.
  logic [DATA_W-1:0] shadow_slots [QDEPTH];
  int unsigned       shadow_head;
  int unsigned       shadow_tail;
  int unsigned       shadow_count;

  always #4 clk = ~clk;

  function automatic outcome_t predict_outcome(logic [OP_W-1:0] op, logic [DATA_W-1:0] data);
    outcome_t o;
    o.removed_value = '0;
    o.status        = ST_DONE;
    o.front_value   = '0;
    o.rear_value    = '0;
    case (op)
      OP_INSERT: begin
        if (shadow_count == QDEPTH) begin
          o.status = ST_FULL;
        end else begin
          shadow_slots[shadow_tail] = data;
          shadow_tail  = (shadow_tail + 1) % QDEPTH;
          shadow_count = shadow_count + 1;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.removed_value = shadow_slots[shadow_head];
          shadow_head  = (shadow_head + 1) % QDEPTH;
          shadow_count = shadow_count - 1;
        end
      end
      OP_CLEAR: begin
        shadow_head  = 0;
        shadow_tail  = 0;
        shadow_count = 0;
      end
      default: ;
    endcase
    if (shadow_count != 0) begin
      o.front_value = shadow_slots[shadow_head];
      o.rear_value  = shadow_slots[(shadow_tail + QDEPTH - 1) % QDEPTH];
    end
    o.occupancy = shadow_count[3:0];
    o.is_empty  = (shadow_count == 0);
    o.is_full   = (shadow_count == QDEPTH);
    return o;
  endfunction

  // Idle percentages per phase: sender light and receiver heavy, then the
  // other way round, then no idling at all.
  function automatic int unsigned idle_pct(bit receiver_side, int n);
    if (n < PHASE1_AT) return receiver_side ? 46 : 10;
    if (n < PHASE2_AT) return receiver_side ? 10 : 46;
    return 0;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] data);
    queue_op_t q;
    q.op          = op;
    q.data        = data;
    q.drain_first = 1'b0;
    op_backlog.push_back(q);
  endtask

  task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Sender: presents backlog items and feeds the predictor on acceptance.
  always @(posedge clk or negedge rst_n) begin : drive_ops
    queue_op_t nxt;
    bit        took;
    bit        may_load;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.operation <= OP_INSERT;
      in_ch.data_in   <= '0;
      accepted_ops    <= 0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        outcome_fifo.push_back(predict_outcome(in_ch.operation, in_ch.data_in));
        accepted_ops <= accepted_ops + 1;
      end
      may_load = (op_backlog.size() != 0)
              && ($urandom_range(99) >= idle_pct(1'b0, accepted_ops));
      // A marked item waits until every outstanding result has come back.
      if (may_load && op_backlog[0].drain_first)
        may_load = !took && (outcome_fifo.size() == 0);
      if (in_ch.valid && !took) begin
        // Hold the item until the queue takes it.
      end else if (may_load) begin
        nxt = op_backlog.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.operation <= nxt.op;
        in_ch.data_in   <= nxt.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off, so that the queue backs up to its input.
  always @(posedge clk or negedge rst_n) begin : long_stall
    if (!rst_n) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && accepted_ops >= STALL_AT) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk or negedge rst_n) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (stall_left == 0)
                   && ($urandom_range(99) >= idle_pct(1'b1, accepted_ops));
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t exp_o;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (outcome_fifo.size() == 0) begin
        $error("result item with no expectation waiting");
        n_fail++;
      end else begin
        exp_o = outcome_fifo.pop_front();
        check_field("removed_value", exp_o.removed_value, out_ch.removed_value);
        check_field("status", 32'(exp_o.status), 32'(out_ch.status));
        check_field("front_value", exp_o.front_value, out_ch.front_value);
        check_field("rear_value", exp_o.rear_value, out_ch.rear_value);
        check_field("occupancy", 32'(exp_o.occupancy), 32'(out_ch.occupancy));
        check_field("is_empty", 32'(exp_o.is_empty), 32'(out_ch.is_empty));
        check_field("is_full", 32'(exp_o.is_full), 32'(out_ch.is_full));
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : run_test
    int unsigned ins_pct;
    int unsigned r;
    logic [OP_W-1:0] op;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.data_in   = '0;
    out_ch.ready    = 1'b0;
    n_fail          = 0;
    shadow_head     = 0;
    shadow_tail     = 0;
    shadow_count    = 0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;

    // Directed part: empty and full refusals, extreme words, wrap-around,
    // clear on a loaded and on an empty queue, and the unused code.
    add_op(OP_REMOVE, 32'h1234_5678);
    add_op(OP_INSERT, 32'h0000_0000);
    add_op(OP_INSERT, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) add_op(OP_INSERT, 32'h1111_1111 * (i + 1));
    add_op(OP_INSERT, 32'hDEAD_BEEF);
    add_op(OP_UNUSED, 32'hFFFF_FFFF);
    add_op(OP_REMOVE, '0);
    add_op(OP_REMOVE, '0);
    add_op(OP_REMOVE, '0);
    add_op(OP_INSERT, 32'hA5A5_5A5A);
    add_op(OP_INSERT, 32'h8000_0001);
    add_op(OP_CLEAR, 32'hFFFF_FFFF);
    add_op(OP_REMOVE, '0);
    add_op(OP_UNUSED, '0);
    add_op(OP_CLEAR, '0);
    add_op(OP_INSERT, 32'h5555_AAAA);
    add_op(OP_REMOVE, '0);

    // Random part in bursts that lean toward filling, draining or neither,
    // so that both the full and the empty boundary are hit often.
    ins_pct = 48;
    for (int i = 0; i < RAND_OPS; i++) begin
      if (i % 24 == 0) begin
        case ($urandom_range(2))
          0:       ins_pct = 70;
          1:       ins_pct = 25;
          default: ins_pct = 48;
        endcase
      end
      r = $urandom_range(99);
      if (r < 3)                op = OP_CLEAR;
      else if (r < 5)           op = OP_UNUSED;
      else if (r < 5 + ins_pct) op = OP_INSERT;
      else                      op = OP_REMOVE;
      add_op(op, rand_word());
    end
    op_backlog[DRAIN_AT].drain_first = 1'b1;
    total_ops = op_backlog.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_ops != total_ops || outcome_fifo.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (n_fail == 0 && outcome_fifo.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule : circular_fifo_queue_tb

`default_nettype wire

// File: filelist.f
src/cfq_pkg.sv
src/cfq_if.sv
src/cfq_cell.sv
src/circular_fifo_queue.sv
src/cfq_checker.sv
tb/sv/circular_fifo_queue_tb.sv
